[src/mcurf_pkg.sv]
// Shared types and constants for the MCU special-function register file.
// Used by every module under src; depends on nothing.
package mcurf_pkg;

   // Register file geometry
   localparam int REG_COUNT_DEFAULT = 32;
   localparam int ADDR_W            = 5;
   localparam int GP_FIRST          = 7;   // first general-purpose address

   // Request commands
   localparam logic [2:0] CMD_READ         = 3'd0;
   localparam logic [2:0] CMD_WRITE        = 3'd1;
   localparam logic [2:0] CMD_RESET        = 3'd2;
   localparam logic [2:0] CMD_SET_GPIO     = 3'd3;
   localparam logic [2:0] CMD_WRITE_PINS   = 3'd4;
   localparam logic [2:0] CMD_WRITE_OPTION = 3'd5;
   localparam logic [2:0] CMD_SLEEP        = 3'd6;

   // Special register addresses
   localparam logic [ADDR_W-1:0] ADDR_INDF   = 5'd0;
   localparam logic [ADDR_W-1:0] ADDR_TMR0   = 5'd1;
   localparam logic [ADDR_W-1:0] ADDR_PCL    = 5'd2;
   localparam logic [ADDR_W-1:0] ADDR_STATUS = 5'd3;
   localparam logic [ADDR_W-1:0] ADDR_FSR    = 5'd4;
   localparam logic [ADDR_W-1:0] ADDR_OSCCAL = 5'd5;
   localparam logic [ADDR_W-1:0] ADDR_GPIO   = 5'd6;

   // Reset causes
   localparam logic [2:0] KIND_POWER_ON    = 3'd0;
   localparam logic [2:0] KIND_MCLR_AWAKE  = 3'd1;
   localparam logic [2:0] KIND_MCLR_ASLEEP = 3'd2;
   localparam logic [2:0] KIND_WDT_ASLEEP  = 3'd3;
   localparam logic [2:0] KIND_WDT_AWAKE   = 3'd4;
   localparam logic [2:0] KIND_WAKE_PIN    = 3'd5;

   // Reset values
   localparam logic [8:0]  PC_RESET      = 9'h1FF;
   localparam logic [7:0]  OPTION_RESET  = 8'hFF;
   localparam logic [7:0]  STATUS_POR    = 8'h18;
   localparam logic [7:0]  OSCCAL_RESET  = 8'hFE;
   localparam logic [11:0] CONFIG_RESET  = 12'hFFF;
   localparam logic [7:0]  STATUS_KEEP   = 8'h18;  // bits a write cannot touch
   localparam int          CFG_MCLR_BIT  = 4;
   localparam int          OPT_PSA_BIT   = 3;
   localparam int          OPT_NWAKE_BIT = 7;

   typedef struct packed {
      logic [2:0]        command;
      logic [ADDR_W-1:0] reg_addr;
      logic [7:0]        write_data;
      logic [2:0]        reset_request_kind;
      logic [5:0]        pin_select;
      logic              pin_level;
   } mcurf_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       reset_taken;
      logic [2:0] reset_cause;
      logic [8:0] pc_now;
   } mcurf_rsp_type;

endpackage

[src/mcu_register_file_reset_pins.sv]
// Top level of the MCU special-function register file with reset and pin logic.
// Depends on mcurf_pkg, mcurf_req_reg, mcurf_core and mcurf_rsp_reg.
// A request waits in the input register, passes once through the core logic and has its
// response registered. Throughput: one request per cycle unless rsp_ready holds it back.
// Reset (synchronous, active high) empties both registers and restores the power-on
// special registers; general-purpose bytes and TMR0 stay undefined until written.
module mcu_register_file_reset_pins #(
   parameter int REG_COUNT = mcurf_pkg::REG_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [4:0]  req_reg_addr,
   input  logic [7:0]  req_write_data,
   input  logic [2:0]  req_reset_request_kind,
   input  logic [5:0]  req_pin_select,
   input  logic        req_pin_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_reset_taken,
   output logic [2:0]  rsp_reset_cause,
   output logic [8:0]  rsp_pc_now,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data
);

   mcurf_pkg::mcurf_req_type req_bus, hold_req;
   mcurf_pkg::mcurf_rsp_type core_rsp, rsp_bus;
   logic                     hold_valid;
   logic                     load_ok;
   logic                     issue;

   // Pack the request ports
   always_comb begin
      req_bus.command            = req_command;
      req_bus.reg_addr           = req_reg_addr;
      req_bus.write_data         = req_write_data;
      req_bus.reset_request_kind = req_reset_request_kind;
      req_bus.pin_select         = req_pin_select;
      req_bus.pin_level          = req_pin_level;
   end

   // A held request moves on when the result register can take it
   assign issue = hold_valid && load_ok;

   mcurf_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .new_req    (req_bus),
      .issue      (issue),
      .hold_valid (hold_valid),
      .hold_req   (hold_req)
   );

   mcurf_core #(
      .REG_COUNT (REG_COUNT)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .issue            (issue),
      .req              (hold_req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp              (core_rsp)
   );

   mcurf_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .rsp_in    (core_rsp),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_out   (rsp_bus)
   );

   // Unpack the response ports
   assign rsp_read_data   = rsp_bus.read_data;
   assign rsp_reset_taken = rsp_bus.reset_taken;
   assign rsp_reset_cause = rsp_bus.reset_cause;
   assign rsp_pc_now      = rsp_bus.pc_now;

endmodule

[src/mcurf_req_reg.sv]
// Input register of the register file: holds one request until the core takes it.
// Depends on mcurf_pkg.
module mcurf_req_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mcurf_pkg::mcurf_req_type new_req,
   input  logic                   issue,
   output logic                   hold_valid,
   output mcurf_pkg::mcurf_req_type hold_req
);

   logic                    valid_ff, valid_in;
   mcurf_pkg::mcurf_req_type req_ff, req_in;

   // accept whenever the held request is empty or leaves this cycle
   assign req_ready = !valid_ff || issue;

   always_comb begin
      valid_in = valid_ff;
      req_in   = req_ff;
      if (req_ready) begin
         valid_in = req_valid;
         req_in   = new_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
   end

   assign hold_valid = valid_ff;
   assign hold_req   = req_ff;

endmodule

[src/mcurf_core.sv]
// Register file state and the single-pass read/write/reset logic for one request.
// Depends on mcurf_pkg.
module mcurf_core #(
   parameter int REG_COUNT = mcurf_pkg::REG_COUNT_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    issue,
   input  mcurf_pkg::mcurf_req_type req,
   input  logic                    csr_write_enable,
   input  logic [11:0]             csr_write_data,
   output mcurf_pkg::mcurf_rsp_type rsp
);

   // Special registers
   logic [8:0]  pc_ff, pc_in;
   logic [7:0]  option_ff, option_in;
   logic [7:0]  prescale_ff, prescale_in;
   logic [1:0]  inhibit_ff, inhibit_in;
   logic        sleeping_ff, sleeping_in;
   logic [7:0]  status_ff, status_in;
   logic [4:0]  fsr_ff, fsr_in;        // bits 7:5 always read as one
   logic [7:0]  osccal_ff, osccal_in;
   logic [5:0]  gpio_ff, gpio_in;
   logic [7:0]  tmr0_ff, tmr0_in;
   logic [11:0] config_ff;

   // General-purpose bytes, undefined until written
   logic [7:0] gp_ff [mcurf_pkg::GP_FIRST:REG_COUNT-1];

   logic [mcurf_pkg::ADDR_W-1:0] eff_addr;
   logic                         gp_we;
   logic                         gpio_change;
   logic [5:0]                   gpio_new;
   logic [5:0]                   gpio_diff;
   logic                         do_reset;
   logic [2:0]                   reset_kind;
   logic [2:0]                   cause;
   logic [7:0]                   read_value;

   // STATUS value left by a reset of the given cause
   function automatic logic [7:0] reset_status(input logic [2:0] kind, input logic [7:0] s);
      logic [7:0] ns;
      case (kind)
         mcurf_pkg::KIND_MCLR_AWAKE:  ns = s & 8'h1F;
         mcurf_pkg::KIND_MCLR_ASLEEP: ns = 8'h10 | (s & 8'h07);
         mcurf_pkg::KIND_WDT_ASLEEP:  ns = s & 8'h07;
         mcurf_pkg::KIND_WDT_AWAKE:   ns = s & 8'h0F;
         mcurf_pkg::KIND_WAKE_PIN:    ns = 8'h90 | (s & 8'h07);
         default:                     ns = mcurf_pkg::STATUS_POR;
      endcase
      return ns;
   endfunction

   // Reported cause; unknown kinds count as power-on
   function automatic logic [2:0] reset_code(input logic [2:0] kind);
      logic [2:0] c;
      case (kind)
         mcurf_pkg::KIND_MCLR_AWAKE,
         mcurf_pkg::KIND_MCLR_ASLEEP,
         mcurf_pkg::KIND_WDT_ASLEEP,
         mcurf_pkg::KIND_WDT_AWAKE,
         mcurf_pkg::KIND_WAKE_PIN:    c = kind;
         default:                     c = mcurf_pkg::KIND_POWER_ON;
      endcase
      return c;
   endfunction

   // Next state for the request in flight
   always_comb begin
      eff_addr    = (req.reg_addr == mcurf_pkg::ADDR_INDF) ? fsr_ff : req.reg_addr;
      pc_in       = pc_ff;
      option_in   = option_ff;
      prescale_in = prescale_ff;
      inhibit_in  = inhibit_ff;
      sleeping_in = sleeping_ff;
      status_in   = status_ff;
      fsr_in      = fsr_ff;
      osccal_in   = osccal_ff;
      gpio_in     = gpio_ff;
      tmr0_in     = tmr0_ff;
      gp_we       = 1'b0;
      gpio_change = 1'b0;
      gpio_new    = gpio_ff;
      do_reset    = 1'b0;
      reset_kind  = mcurf_pkg::KIND_POWER_ON;
      cause       = mcurf_pkg::KIND_POWER_ON;

      case (req.command)
         mcurf_pkg::CMD_WRITE: begin
            case (eff_addr)
               mcurf_pkg::ADDR_INDF: begin
                  // indirect through INDF itself: ignored
               end
               mcurf_pkg::ADDR_TMR0: begin
                  if (!option_ff[mcurf_pkg::OPT_PSA_BIT]) begin
                     prescale_in = 8'd0;
                     inhibit_in  = 2'd2;
                  end
                  tmr0_in = req.write_data;
               end
               mcurf_pkg::ADDR_PCL:    pc_in = {1'b0, req.write_data};
               mcurf_pkg::ADDR_STATUS: status_in = (status_ff & mcurf_pkg::STATUS_KEEP)
                                                 | (req.write_data & ~mcurf_pkg::STATUS_KEEP);
               mcurf_pkg::ADDR_FSR:    fsr_in = req.write_data[4:0];
               mcurf_pkg::ADDR_OSCCAL: osccal_in = req.write_data;
               mcurf_pkg::ADDR_GPIO:   gpio_in = req.write_data[5:0];
               default:                gp_we = 1'b1;
            endcase
         end
         mcurf_pkg::CMD_RESET: begin
            do_reset   = 1'b1;
            reset_kind = req.reset_request_kind;
         end
         mcurf_pkg::CMD_SET_GPIO: begin
            gpio_change = 1'b1;
            gpio_new    = req.write_data[5:0];
         end
         mcurf_pkg::CMD_WRITE_PINS: begin
            gpio_change = 1'b1;
            gpio_new    = req.pin_level ? (gpio_ff | req.pin_select)
                                        : (gpio_ff & ~req.pin_select);
         end
         mcurf_pkg::CMD_WRITE_OPTION: option_in = req.write_data;
         mcurf_pkg::CMD_SLEEP:        sleeping_in = 1'b1;
         default: begin
         end
      endcase

      // Pin change: MCLR on GP3 first, then wake on GP0/GP1/GP3
      gpio_diff = gpio_ff ^ gpio_new;
      if (gpio_change) begin
         gpio_in = gpio_new;
         if (config_ff[mcurf_pkg::CFG_MCLR_BIT] && gpio_diff[3]) begin
            do_reset   = 1'b1;
            reset_kind = sleeping_ff ? mcurf_pkg::KIND_MCLR_ASLEEP : mcurf_pkg::KIND_MCLR_AWAKE;
         end else if (!option_ff[mcurf_pkg::OPT_NWAKE_BIT]
                      && (gpio_diff[0] || gpio_diff[1] || gpio_diff[3])) begin
            do_reset   = 1'b1;
            reset_kind = mcurf_pkg::KIND_WAKE_PIN;
         end
      end

      // Reset command or pin-caused reset
      if (do_reset) begin
         pc_in       = mcurf_pkg::PC_RESET;
         option_in   = mcurf_pkg::OPTION_RESET;
         prescale_in = 8'd0;
         inhibit_in  = 2'd0;
         sleeping_in = 1'b0;
         status_in   = reset_status(reset_kind, status_ff);
         cause       = reset_code(reset_kind);
      end
   end

   // Register read with INDF, PCL and unimplemented-bit rules
   always_comb begin
      case (eff_addr)
         mcurf_pkg::ADDR_INDF:   read_value = 8'h00;
         mcurf_pkg::ADDR_TMR0:   read_value = tmr0_ff;
         mcurf_pkg::ADDR_PCL:    read_value = pc_ff[7:0];
         mcurf_pkg::ADDR_STATUS: read_value = status_ff;
         mcurf_pkg::ADDR_FSR:    read_value = {3'b111, fsr_ff};
         mcurf_pkg::ADDR_OSCCAL: read_value = osccal_ff;
         mcurf_pkg::ADDR_GPIO:   read_value = {2'b00, gpio_ff};
         default:                read_value = gp_ff[eff_addr];
      endcase
   end

   // Result of this request
   always_comb begin
      rsp.read_data   = (req.command == mcurf_pkg::CMD_READ) ? read_value
                                                             : {2'b00, gpio_in & req.pin_select};
      rsp.reset_taken = do_reset;
      rsp.reset_cause = cause;
      rsp.pc_now      = pc_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff       <= mcurf_pkg::PC_RESET;
         option_ff   <= mcurf_pkg::OPTION_RESET;
         prescale_ff <= 8'd0;
         inhibit_ff  <= 2'd0;
         sleeping_ff <= 1'b0;
         status_ff   <= mcurf_pkg::STATUS_POR;
         fsr_ff      <= 5'd0;
         osccal_ff   <= mcurf_pkg::OSCCAL_RESET;
         gpio_ff     <= 6'd0;
         config_ff   <= mcurf_pkg::CONFIG_RESET;
      end else begin
         if (issue) begin
            pc_ff       <= pc_in;
            option_ff   <= option_in;
            prescale_ff <= prescale_in;
            inhibit_ff  <= inhibit_in;
            sleeping_ff <= sleeping_in;
            status_ff   <= status_in;
            fsr_ff      <= fsr_in;
            osccal_ff   <= osccal_in;
            gpio_ff     <= gpio_in;
         end
         if (csr_write_enable) begin
            config_ff <= csr_write_data;
         end
      end
   end

   // Timer and general-purpose bytes: no reset
   always_ff @(posedge clock) begin
      if (issue) begin
         tmr0_ff <= tmr0_in;
      end
      if (issue && gp_we) begin
         gp_ff[eff_addr] <= req.write_data;
      end
   end

   // Checks
   a_reset_restores: assert property (@(posedge clock) disable iff (reset)
      issue && rsp.reset_taken |=> pc_ff == mcurf_pkg::PC_RESET && !sleeping_ff
                                   && option_ff == mcurf_pkg::OPTION_RESET
                                   && inhibit_ff == 2'd0)
      else $error("reset did not restore pc, option, sleep and inhibit");

   a_cause_needs_reset: assert property (@(posedge clock) disable iff (reset)
      issue && rsp.reset_cause != mcurf_pkg::KIND_POWER_ON |-> rsp.reset_taken)
      else $error("reset cause reported without a reset");

   a_status_protected: assert property (@(posedge clock) disable iff (reset)
      !(issue && rsp.reset_taken) |=> $stable(status_ff[4:3]))
      else $error("STATUS bits 4:3 changed without a reset");

   a_pin_read_width: assert property (@(posedge clock) disable iff (reset)
      issue && req.command != mcurf_pkg::CMD_READ |-> rsp.read_data[7:6] == 2'b00)
      else $error("pin read returned bits above GPIO width");

   a_inhibit_from_tmr0: assert property (@(posedge clock) disable iff (reset)
      issue && req.command != mcurf_pkg::CMD_WRITE && !rsp.reset_taken
      |=> $stable(inhibit_ff))
      else $error("timer inhibit changed outside a TMR0 write or reset");

endmodule

[src/mcurf_rsp_reg.sv]
// Result register of the register file: holds one response until taken.
// Depends on mcurf_pkg.
module mcurf_rsp_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    issue,
   input  mcurf_pkg::mcurf_rsp_type rsp_in,
   output logic                    load_ok,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mcurf_pkg::mcurf_rsp_type rsp_out
);

   logic                     valid_ff, valid_in;
   mcurf_pkg::mcurf_rsp_type rsp_ff;

   // free when empty or the held response is taken this cycle
   assign load_ok = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load_ok) begin
         valid_in = issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (issue) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = rsp_ff;

endmodule
